// ===== rtl/tsv_pkg.sv =====
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types and constants for the text stream visualizer.
// ----------------------------------------------------------------------------
package tsv_pkg;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgNumberAll    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNumberNonblk = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSqueezeBlank = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgShowEnds     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgShowTabs     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShowNonprint = 3'd5;

  localparam logic [7:0] ChTab      = 8'd9;
  localparam logic [7:0] ChNewline  = 8'd10;
  localparam logic [7:0] ChSpace    = 8'd32;
  localparam logic [7:0] ChDollar   = 8'd36;
  localparam logic [7:0] ChZero     = 8'd48;
  localparam logic [7:0] ChQuestion = 8'd63;
  localparam logic [7:0] ChUpperI   = 8'd73;
  localparam logic [7:0] ChCaret    = 8'd94;
  localparam logic [7:0] ChDel      = 8'd127;
  localparam logic [7:0] CaretShift = 8'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprint;
  } cfg_t;

  // one classified input byte, waiting to be expanded into beats
  typedef struct packed {
    logic       has_num;
    logic       has_pre;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
  } job_ctl_t;

endpackage

// ===== rtl/tsv_front.sv =====
// ----------------------------------------------------------------------------
// tsv_front
// Classifies each input byte, keeps the line counter and squeeze state.
// ----------------------------------------------------------------------------
module tsv_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsv_pkg::cfg_t              cfg_i,
  input  logic                       accept_i,
  input  tsv_pkg::in_item_t          item_i,
  output logic                       job_push_o,
  output tsv_pkg::job_ctl_t          job_o,
  output logic [4*NUMBER_DIGITS-1:0] digits_o
);
  import tsv_pkg::*;

  localparam int NumW = 4 * NUMBER_DIGITS;

  logic [NumW-1:0] num_q, num_d, num_cur, num_inc;
  logic [1:0]      run_q, run_d, run_cur, run_inc;
  logic            prev_nl_q, prev_nl_d, line_start;
  logic [7:0]      c;
  logic            is_nl, is_ctrl, squeeze_case, drop, has_num, carry;
  logic [3:0]      dig;

  assign c          = item_i.in_byte;
  assign is_nl      = (c == ChNewline);
  assign num_cur    = item_i.file_start ? NumW'(1) : num_q;
  assign run_cur    = item_i.file_start ? 2'd0 : run_q;
  assign line_start = item_i.file_start | prev_nl_q;

  assign squeeze_case = cfg_i.squeeze_blank & is_nl & line_start;
  assign run_inc      = (run_cur < 2'd2) ? run_cur + 2'd1 : run_cur;
  assign drop         = squeeze_case & (run_inc > 2'd1);
  assign run_d        = squeeze_case ? run_inc : 2'd0;

  always_comb begin
    if (cfg_i.number_nonblank) begin
      has_num = line_start & ~is_nl;
    end else begin
      has_num = cfg_i.number_all & line_start;
    end
    has_num = has_num & ~drop;
  end

  // bcd increment, holds at all nines
  always_comb begin
    carry   = 1'b1;
    dig     = 4'd0;
    num_inc = num_cur;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      dig = num_cur[4*i +: 4];
      if (carry) begin
        num_inc[4*i +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
      end
      carry = carry & (dig == 4'd9);
    end
    if (carry) begin
      num_inc = num_cur;
    end
  end

  assign is_ctrl = (c < ChTab) || ((c > ChNewline) && (c < ChSpace)) || (c == ChDel);

  always_comb begin
    job_o.has_num   = has_num;
    job_o.has_pre   = 1'b0;
    job_o.pre_byte  = ChCaret;
    job_o.main_byte = c;
    if (cfg_i.show_tabs && (c == ChTab)) begin
      job_o.has_pre   = 1'b1;
      job_o.main_byte = ChUpperI;
    end else if (cfg_i.show_ends && is_nl) begin
      job_o.has_pre  = 1'b1;
      job_o.pre_byte = ChDollar;
    end else if (cfg_i.show_nonprint && is_ctrl) begin
      job_o.has_pre   = 1'b1;
      job_o.main_byte = (c == ChDel) ? ChQuestion : c + CaretShift;
    end
  end

  assign digits_o   = num_cur;
  assign job_push_o = accept_i & ~drop;
  assign num_d      = has_num ? num_inc : num_cur;
  // only a newline leaves a newline as the last body byte
  assign prev_nl_d  = drop ? line_start : is_nl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q     <= NumW'(1);
      run_q     <= 2'd0;
      prev_nl_q <= 1'b1;
    end else if (accept_i) begin
      num_q     <= num_d;
      run_q     <= run_d;
      prev_nl_q <= prev_nl_d;
    end
  end

endmodule

// ===== rtl/tsv_fifo.sv =====
// ----------------------------------------------------------------------------
// tsv_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module tsv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/tsv_back.sv =====
// ----------------------------------------------------------------------------
// tsv_back
// Expands each job into output beats, one beat per cycle while the output is taken.
// ----------------------------------------------------------------------------
module tsv_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_avail_i,
  input  tsv_pkg::job_ctl_t          job_i,
  input  logic [4*NUMBER_DIGITS-1:0] digits_i,
  output logic                       job_pop_o,
  output logic                       out_valid_o,
  output tsv_pkg::out_item_t         out_o,
  input  logic                       out_take_i
);
  import tsv_pkg::*;

  localparam int NumW = 4 * NUMBER_DIGITS;
  localparam int PosW = $clog2(NUMBER_DIGITS + 3);
  localparam logic [PosW-1:0] PosTab  = PosW'(NUMBER_DIGITS);
  localparam logic [PosW-1:0] PosPre  = PosW'(NUMBER_DIGITS + 1);
  localparam logic [PosW-1:0] PosMain = PosW'(NUMBER_DIGITS + 2);

  job_ctl_t        job_q;
  logic [NumW-1:0] digits_q;
  logic            busy_q, out_valid_q;
  logic [PosW-1:0] pos_q, pos_next, pos_start;
  out_item_t       out_q;
  logic [7:0]      cur_byte;
  logic            is_last, emit, load;
  logic [NUMBER_DIGITS-1:0] zero_above;

  // digit i is blank if it and all higher digits are zero, except the lowest
  always_comb begin
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      zero_above[i] = (i != 0);
      for (int j = i; j < NUMBER_DIGITS; j++) begin
        if (digits_q[4*j +: 4] != 4'd0) begin
          zero_above[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cur_byte = job_q.main_byte;
    if (pos_q == PosTab) begin
      cur_byte = ChTab;
    end else if (pos_q == PosPre) begin
      cur_byte = job_q.pre_byte;
    end else if (pos_q != PosMain) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (pos_q == PosW'(NUMBER_DIGITS - 1 - i)) begin
          cur_byte = zero_above[i] ? ChSpace : ChZero + {4'd0, digits_q[4*i +: 4]};
        end
      end
    end
  end

  always_comb begin
    if (pos_q == PosTab) begin
      pos_next = job_q.has_pre ? PosPre : PosMain;
    end else if (pos_q == PosPre) begin
      pos_next = PosMain;
    end else begin
      pos_next = pos_q + PosW'(1);
    end
  end

  always_comb begin
    if (job_i.has_num) begin
      pos_start = '0;
    end else if (job_i.has_pre) begin
      pos_start = PosPre;
    end else begin
      pos_start = PosMain;
    end
  end

  assign is_last     = (pos_q == PosMain);
  assign emit        = busy_q & (~out_valid_q | out_take_i);
  assign load        = job_avail_i & (~busy_q | (emit & is_last));
  assign job_pop_o   = load;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q    <= job_i;
      digits_q <= digits_i;
    end
    if (emit) begin
      out_q.out_byte <= cur_byte;
      out_q.last     <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        pos_q  <= pos_start;
      end else if (emit) begin
        busy_q <= ~is_last;
        pos_q  <= pos_next;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/text_stream_visualizer.sv =====
// ----------------------------------------------------------------------------
// text_stream_visualizer
// Cat-style byte filter: numbering, blank squeezing, visible ends and controls.
// ----------------------------------------------------------------------------
// Each accepted byte gives from one to NUMBER_DIGITS+3 output beats (none for a
// squeezed blank line); the final beat of a byte carries last. The output side
// sends one beat per cycle while the receiver keeps popping; most bytes give
// one or two beats, up to nine at a numbered line start with six digits.
// The front end classifies a byte in the cycle it is accepted and hands it
// through a two-entry job queue to the back end, which expands it into beats;
// its first beat is registered after the queue and the back end's job register.
// Configuration bits take effect on the next byte; line number, newline run and
// previous byte restart whenever file_start is set on a byte.
// ----------------------------------------------------------------------------
module text_stream_visualizer #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  tsv_pkg::in_item_t               in_data_i,
  output logic                            empty,
  input  logic                            pop,
  output tsv_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tsv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [0:0]                      cfg_wdata_i
);
  import tsv_pkg::*;

  localparam int NumW     = 4 * NUMBER_DIGITS;
  localparam int JobW     = $bits(job_ctl_t) + NumW;
  localparam int JobDepth = 2;

  cfg_t            cfg_q;
  logic            accept, job_push, fifo_full, fifo_empty, fifo_pop, out_valid;
  job_ctl_t        front_job, back_job;
  logic [NumW-1:0] front_digits, back_digits;
  logic [JobW-1:0] fifo_wdata, fifo_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumberAll:    cfg_q.number_all      <= cfg_wdata_i[0];
        CfgNumberNonblk: cfg_q.number_nonblank <= cfg_wdata_i[0];
        CfgSqueezeBlank: cfg_q.squeeze_blank   <= cfg_wdata_i[0];
        CfgShowEnds:     cfg_q.show_ends       <= cfg_wdata_i[0];
        CfgShowTabs:     cfg_q.show_tabs       <= cfg_wdata_i[0];
        CfgShowNonprint: cfg_q.show_nonprint   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign full   = fifo_full;
  assign accept = push & ~fifo_full;

  tsv_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .job_push_o (job_push),
    .job_o      (front_job),
    .digits_o   (front_digits)
  );

  assign fifo_wdata = {front_job, front_digits};
  assign back_job    = job_ctl_t'(fifo_rdata[JobW-1:NumW]);
  assign back_digits = fifo_rdata[NumW-1:0];

  tsv_fifo #(
    .WIDTH(JobW),
    .DEPTH(JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  tsv_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (~fifo_empty),
    .job_i       (back_job),
    .digits_i    (back_digits),
    .job_pop_o   (fifo_pop),
    .out_valid_o (out_valid),
    .out_o       (out_data_o),
    .out_take_i  (pop)
  );

  assign empty = ~out_valid;

endmodule

// ===== test/text_stream_visualizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_stream_visualizer_test
// Self-checking bench for the byte filter: a scoreboard predicts the output
// beats of every accepted byte and compares them in order with what the block
// pops out, over directed bytes and random text under several option sets.
// ----------------------------------------------------------------------------
module text_stream_visualizer_test;
  import tsv_pkg::*;

  localparam int NumDigits  = 6;
  localparam int CycleLimit = 300000;
  localparam int DrainWait  = 10;

  class line_filter_scoreboard;
    cfg_t        cfg;
    int unsigned line_no;
    logic [1:0]  nl_run;
    logic [7:0]  prev_byte;
    out_item_t   expected_beats[$];
    int unsigned bytes_taken;
    int unsigned beats_checked;
    int unsigned mismatches;

    function new();
      cfg = '0;
      bytes_taken = 0;
      beats_checked = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      line_no = 1;
      nl_run = '0;
      prev_byte = ChNewline;
    endfunction

    function void add_beat(logic [7:0] b);
      out_item_t beat;
      beat.out_byte = b;
      beat.last = 1'b0;
      expected_beats.push_back(beat);
    endfunction

    function void add_number();
      int unsigned digit[NumDigits];
      int unsigned v;
      int unsigned top;
      bit lead;
      v = line_no;
      top = 1;
      lead = 1'b1;
      for (int i = NumDigits - 1; i >= 0; i--) begin
        digit[i] = v % 10;
        v = v / 10;
        top = top * 10;
      end
      for (int i = 0; i < NumDigits; i++) begin
        if (digit[i] != 0 || i == NumDigits - 1) lead = 1'b0;
        add_beat(lead ? ChSpace : ChZero + 8'(digit[i]));
      end
      add_beat(ChTab);
      if (line_no < top - 1) line_no++;
    endfunction

    // predicts the beats of one accepted byte
    function void note_input(in_item_t item);
      logic [7:0] c;
      bit at_start;
      out_item_t tail;
      bytes_taken++;
      c = item.in_byte;
      if (item.file_start) restart();
      at_start = (prev_byte == ChNewline);
      if (cfg.squeeze_blank && c == ChNewline && at_start) begin
        if (nl_run < 2) nl_run++;
        if (nl_run > 1) return;
      end else begin
        nl_run = '0;
      end
      if (cfg.number_nonblank) begin
        if (at_start && c != ChNewline) add_number();
      end else if (cfg.number_all && at_start) begin
        add_number();
      end
      if (cfg.show_tabs && c == ChTab) begin
        add_beat(ChCaret);
        c = ChUpperI;
      end
      if (cfg.show_ends && c == ChNewline) add_beat(ChDollar);
      if (cfg.show_nonprint &&
          (c < ChTab || (c > ChNewline && c < ChSpace) || c == ChDel)) begin
        add_beat(ChCaret);
        if (c == ChDel) begin
          add_beat(ChQuestion);
          c = ChDel;
        end else begin
          c = c + CaretShift;
          add_beat(c);
        end
      end else begin
        add_beat(c);
      end
      prev_byte = c;
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    endfunction

    task report(string field, int got, int want);
      $display("mismatch in %s at beat %0d: got 'h%0h, expected 'h%0h",
               field, beats_checked, got, want);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", got, 0);
      end else begin
        want = expected_beats.pop_front();
        if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
      beats_checked++;
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_item_t           in_data_i;
  logic               empty;
  logic               pop;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [0:0]         cfg_wdata_i;

  line_filter_scoreboard sb = new();
  bit          no_idle;
  int unsigned cycles;

  text_stream_visualizer #(
    .NUMBER_DIGITS(NumDigits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_data_o);
  end

  // receiver: random stalls, plus one long hold-off once traffic is underway
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_once && sb.bytes_taken >= 100) begin
        held_once = 1'b1;
        hold_left = 160;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || $urandom_range(99) >= 21;
      end
    end
  end

  function automatic in_item_t mk(logic [7:0] b, logic fs);
    in_item_t item;
    item.in_byte = b;
    item.file_start = fs;
    return item;
  endfunction

  // mostly text-like bytes, with controls, high bytes and file restarts mixed in
  function automatic in_item_t next_text_byte();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 45) b = 8'($urandom_range(32, 126));
    else if (r < 66) b = ChNewline;
    else if (r < 72) b = ChTab;
    else if (r < 80) b = 8'($urandom_range(0, 31));
    else if (r < 84) b = ChDel;
    else if (r < 90) b = 8'($urandom_range(128, 255));
    else b = 8'($urandom);
    return mk(b, $urandom_range(99) < 3);
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(in_item_t item);
    while (!no_idle && $urandom_range(99) < 21) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (full);
    sb.note_input(item);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // writes every index, the unused ones too
  task automatic write_options(cfg_t c);
    logic [CfgIdxW-1:0] idx;
    logic               v;
    for (int i = 0; i < (1 << CfgIdxW); i++) begin
      idx = CfgIdxW'(i);
      case (idx)
        CfgNumberAll:    v = c.number_all;
        CfgNumberNonblk: v = c.number_nonblank;
        CfgSqueezeBlank: v = c.squeeze_blank;
        CfgShowEnds:     v = c.show_ends;
        CfgShowTabs:     v = c.show_tabs;
        CfgShowNonprint: v = c.show_nonprint;
        default:         v = 1'($urandom);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= v;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.cfg = c;
  endtask

  initial begin
    logic [7:0] all_on_bytes[14];
    logic [7:0] squeeze_bytes[7];
    cfg_t       c;
    logic [5:0] pick;
    all_on_bytes = '{8'h41, ChTab, 8'h00, 8'h08, 8'h0b, 8'h1f, ChDel, 8'h80, 8'hff,
                     ChNewline, ChNewline, ChNewline, 8'h62, ChNewline};
    squeeze_bytes = '{8'h78, ChNewline, ChNewline, ChNewline, 8'h79, ChNewline, ChNewline};
    rst_ni = 1'b0;
    push = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    no_idle = 1'b0;
    cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // options as they come out of reset
    send_byte(mk(8'h41, 1'b0));
    send_byte(mk(ChTab, 1'b0));
    send_byte(mk(8'h01, 1'b0));
    send_byte(mk(ChNewline, 1'b0));
    drain();

    // everything on: nonblank numbering wins over number-all
    write_options('1);
    foreach (all_on_bytes[i]) send_byte(mk(all_on_bytes[i], i == 0));
    drain();

    c = '0;
    c.number_all = 1'b1;
    c.squeeze_blank = 1'b1;
    write_options(c);
    foreach (squeeze_bytes[i]) send_byte(mk(squeeze_bytes[i], i == 0 || i == 6));
    drain();

    for (int p = 0; p < 8; p++) begin
      c = '0;
      case (p)
        0: c = '0;
        1: c = '1;
        2: begin
          c.number_all = 1'b1;
          c.squeeze_blank = 1'b1;
          c.show_ends = 1'b1;
        end
        3: begin
          c.number_nonblank = 1'b1;
          c.show_tabs = 1'b1;
          c.show_nonprint = 1'b1;
        end
        default: begin
          pick = 6'($urandom);
          c = pick;
        end
      endcase
      no_idle = (p == 2);
      write_options(c);
      repeat (30) send_byte(next_text_byte());
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
